// File: design/bldc_six_step_commutator_assert.svh
// Assertion macros used by the checker of the six-step commutator.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BLDC_SIX_STEP_COMMUTATOR_ASSERT_SVH
`define BLDC_SIX_STEP_COMMUTATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BLDC6S_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bldc6s assertion failed: same-cycle rule");

// next-cycle implication, checked outside reset
`define BLDC6S_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bldc6s assertion failed: next-cycle rule");

`endif

// File: design/bldc6s_pkg.sv
// Types, constants and phase tables for the six-step commutator.
// Used by the step logic, the top level and the checker.
package bldc6s_pkg;

  localparam int unsigned PHASE_W = 3;
  localparam int unsigned LEG_W = 2;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned OVF_W = 8;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned STEPS_PER_REV = 6;

  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(NUM_PHASES - 1);
  localparam logic [PHASE_W-1:0] LAST_STEP = PHASE_W'(STEPS_PER_REV - 1);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FORCE = 1'b1;

  localparam logic [LEG_W-1:0] LEG_A = 2'd0;
  localparam logic [LEG_W-1:0] LEG_B = 2'd1;
  localparam logic [LEG_W-1:0] LEG_C = 2'd2;

  typedef struct packed {
    logic               kind;
    logic               comparator_level;
    logic [PHASE_W-1:0] forced_phase;
    logic [OVF_W-1:0]   overflow_count;
    logic               current_sample_request;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LEG_W-1:0]   high_side_leg;
    logic [LEG_W-1:0]   low_side_leg;
    logic [LEG_W-1:0]   comparator_channel;
    logic               comparator_rising;
    logic               commutated;
    logic               start_current_conversion;
    logic [COUNT_W-1:0] commutation_total;
    logic [OVF_W-1:0]   revolution_ticks;
    logic               revolution_done;
  } out_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [COUNT_W-1:0] count;
    logic [PHASE_W-1:0] steps;
    logic [OVF_W-1:0]   last_ovf;
    logic [OVF_W-1:0]   rev_ticks;
    logic [LEG_W-1:0]   cmp_chan;
    logic               cmp_rise;
  } state_t;

  function automatic logic [LEG_W-1:0] drive_high(input logic [PHASE_W-1:0] p);
    logic [LEG_W-1:0] leg;
    unique case (p)
      3'd0, 3'd1: leg = LEG_A;
      3'd2, 3'd3: leg = LEG_B;
      3'd4, 3'd5: leg = LEG_C;
      default:    leg = LEG_A;
    endcase
    return leg;
  endfunction

  function automatic logic [LEG_W-1:0] drive_low(input logic [PHASE_W-1:0] p);
    logic [LEG_W-1:0] leg;
    unique case (p)
      3'd0, 3'd5: leg = LEG_B;
      3'd1, 3'd2: leg = LEG_C;
      3'd3, 3'd4: leg = LEG_A;
      default:    leg = LEG_B;
    endcase
    return leg;
  endfunction

  function automatic logic [LEG_W-1:0] cmp_channel(input logic [PHASE_W-1:0] p);
    logic [LEG_W-1:0] leg;
    unique case (p)
      3'd0, 3'd3: leg = LEG_C;
      3'd1, 3'd4: leg = LEG_B;
      3'd2, 3'd5: leg = LEG_A;
      default:    leg = LEG_C;
    endcase
    return leg;
  endfunction

  // rising edge expected in even phases
  function automatic logic cmp_rising(input logic [PHASE_W-1:0] p);
    return ~p[0];
  endfunction

endpackage

// File: design/bldc6s_step.sv
// One commutation step: next state and result item from the state and an item.
// Depends on bldc6s_pkg.
module bldc6s_step (
  input  bldc6s_pkg::state_t    cur,
  input  bldc6s_pkg::in_item_t  item,
  output bldc6s_pkg::state_t    nxt,
  output bldc6s_pkg::out_item_t res
);
  import bldc6s_pkg::*;

  logic               comm;
  logic               conv;
  logic               rev;
  logic [PHASE_W-1:0] adv_phase;

  assign adv_phase = (cur.phase == LAST_PHASE) ? '0 : cur.phase + 3'd1;

  always_comb begin
    nxt  = cur;
    comm = 1'b0;
    conv = 1'b0;
    rev  = 1'b0;
    if (item.kind == KIND_FORCE) begin
      if (item.forced_phase <= LAST_PHASE) begin
        nxt.phase    = item.forced_phase;
        nxt.cmp_chan = cmp_channel(item.forced_phase);
        nxt.cmp_rise = cmp_rising(item.forced_phase);
      end
    end else if (item.comparator_level == ~cur.phase[0]) begin
      comm         = 1'b1;
      conv         = item.current_sample_request;
      nxt.phase    = adv_phase;
      nxt.cmp_chan = cmp_channel(adv_phase);
      nxt.cmp_rise = cmp_rising(adv_phase);
      nxt.count    = cur.count + 16'd1;
      if (cur.steps == LAST_STEP) begin
        nxt.steps     = '0;
        nxt.rev_ticks = item.overflow_count - cur.last_ovf;
        nxt.last_ovf  = item.overflow_count;
        rev           = 1'b1;
      end else begin
        nxt.steps = cur.steps + 3'd1;
      end
    end
  end

  always_comb begin
    res.phase                    = nxt.phase;
    res.high_side_leg            = drive_high(nxt.phase);
    res.low_side_leg             = drive_low(nxt.phase);
    res.comparator_channel       = nxt.cmp_chan;
    res.comparator_rising        = nxt.cmp_rise;
    res.commutated               = comm;
    res.start_current_conversion = conv;
    res.commutation_total        = nxt.count;
    res.revolution_ticks         = nxt.rev_ticks;
    res.revolution_done          = rev;
  end

endmodule

// File: design/bldc_six_step_commutator.sv
// Top level of the sensorless six-step BLDC commutator.
// Depends on bldc6s_pkg and bldc6s_step.
//
// Usage:
//   Input channel (in_valid, in_stall, in_item) takes comparator samples
//   and force items; result channel (out_valid, out_stall, out_item) gives
//   exactly one result item per input item, in order.
//   An item is taken into an input register, then the step logic updates the
//   commutation state and loads the result register from it.
//   Throughput: 1 item per cycle unless out_stall holds a result; the state
//   update is a single combinational step from input to result register.
//   When out_stall is high with a result waiting, the result register holds,
//   the input register holds its item and in_stall rises until the result
//   is taken.
//   Reset (rst_n low, synchronous) empties both registers, sets phase 0,
//   clears the counters and snapshots, and points the comparator at
//   channel A with a falling edge.
module bldc_six_step_commutator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bldc6s_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bldc6s_pkg::out_item_t out_item
);
  import bldc6s_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  state_t    state_r;
  state_t    state_nxt;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      advance;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  bldc6s_step u_step (
    .cur  (state_r),
    .item (s1_item_r),
    .nxt  (state_nxt),
    .res  (out_item_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: design/bldc6s_checker.sv
// Port-level checks of the six-step commutator, bound to its top level.
// Depends on bldc6s_pkg and bldc_six_step_commutator_assert.svh.
`include "bldc_six_step_commutator_assert.svh"

module bldc6s_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input bldc6s_pkg::out_item_t out_item
);
  import bldc6s_pkg::*;

  `BLDC6S_ASSERT_NOW(a_phase_range, out_valid, out_item.phase <= LAST_PHASE)
  `BLDC6S_ASSERT_NOW(a_legs_differ, out_valid, out_item.high_side_leg != out_item.low_side_leg)
  `BLDC6S_ASSERT_NOW(a_pulse_needs_comm, out_valid && !out_item.commutated, !out_item.start_current_conversion && !out_item.revolution_done)
  `BLDC6S_ASSERT_NOW(a_comm_setting, out_valid && out_item.commutated, out_item.comparator_channel == cmp_channel(out_item.phase) && out_item.comparator_rising == cmp_rising(out_item.phase))
  `BLDC6S_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

endmodule

bind bldc_six_step_commutator bldc6s_checker u_bldc6s_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// File: sim/tb_bldc_six_step_commutator.sv
// Testbench for bldc_six_step_commutator: directed and random comparator-sample
// and force items with random idling and backpressure, results checked against
// an in-bench commutation predictor. Depends on bldc6s_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_bldc_six_step_commutator;
  import bldc6s_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  bldc_six_step_commutator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [LEG_W-1:0] high_leg_of  [0:NUM_PHASES-1] = '{LEG_A, LEG_A, LEG_B, LEG_B, LEG_C, LEG_C};
  logic [LEG_W-1:0] low_leg_of   [0:NUM_PHASES-1] = '{LEG_B, LEG_C, LEG_C, LEG_A, LEG_A, LEG_B};
  logic [LEG_W-1:0] sense_leg_of [0:NUM_PHASES-1] = '{LEG_C, LEG_B, LEG_A, LEG_C, LEG_B, LEG_A};

  logic [PHASE_W-1:0] rotor_phase = '0;
  logic [COUNT_W-1:0] comm_count = '0;
  logic [PHASE_W-1:0] rev_step = '0;
  logic [OVF_W-1:0]   rev_snapshot = '0;
  logic [OVF_W-1:0]   rev_ticks = '0;
  logic [LEG_W-1:0]   sense_leg = LEG_A;
  logic               sense_rising = 1'b0;

  out_item_t   expected_drive_q[$];
  logic [OVF_W-1:0] timer_ovf = '0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;

  function automatic out_item_t next_drive(input in_item_t it);
    out_item_t r;
    logic      hit;
    logic      rev;
    hit = 1'b0;
    rev = 1'b0;
    if (it.kind == KIND_FORCE) begin
      if (it.forced_phase < NUM_PHASES) begin
        rotor_phase = it.forced_phase;
        sense_leg = sense_leg_of[rotor_phase];
        sense_rising = ~rotor_phase[0];
      end
    end else if (it.comparator_level == ~rotor_phase[0]) begin
      hit = 1'b1;
      rotor_phase = (rotor_phase == LAST_PHASE) ? '0 : rotor_phase + 1'b1;
      sense_leg = sense_leg_of[rotor_phase];
      sense_rising = ~rotor_phase[0];
      comm_count = comm_count + 1'b1;
      rev_step = rev_step + 1'b1;
      if (rev_step >= STEPS_PER_REV) begin
        rev_step = '0;
        rev_ticks = it.overflow_count - rev_snapshot;
        rev_snapshot = it.overflow_count;
        rev = 1'b1;
      end
    end
    r.phase = rotor_phase;
    r.high_side_leg = high_leg_of[rotor_phase];
    r.low_side_leg = low_leg_of[rotor_phase];
    r.comparator_channel = sense_leg;
    r.comparator_rising = sense_rising;
    r.commutated = hit;
    r.start_current_conversion = hit & it.current_sample_request;
    r.commutation_total = comm_count;
    r.revolution_ticks = rev_ticks;
    r.revolution_done = rev;
    return r;
  endfunction

  function automatic in_item_t sample_item(input logic level, input logic [OVF_W-1:0] ovf,
                                           input logic req);
    in_item_t it;
    it.kind = KIND_SAMPLE;
    it.comparator_level = level;
    it.forced_phase = PHASE_W'($urandom_range(7));
    it.overflow_count = ovf;
    it.current_sample_request = req;
    return it;
  endfunction

  function automatic in_item_t force_item(input logic [PHASE_W-1:0] p);
    in_item_t it;
    it.kind = KIND_FORCE;
    it.comparator_level = 1'($urandom_range(1));
    it.forced_phase = p;
    it.overflow_count = OVF_W'($urandom_range(255));
    it.current_sample_request = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic in_item_t random_item(input int unsigned commute_pct,
                                           input int unsigned force_pct);
    logic lvl;
    if ($urandom_range(99) < force_pct)
      return force_item(PHASE_W'($urandom_range(7)));
    lvl = ($urandom_range(99) < commute_pct) ? ~rotor_phase[0] : logic'($urandom_range(1));
    timer_ovf = timer_ovf + OVF_W'($urandom_range(12));
    return sample_item(lvl, timer_ovf, 1'($urandom_range(1)));
  endfunction

  task automatic send_item(input in_item_t it);
    while (idle_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_drive_q.push_back(next_drive(it));
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_drive_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: unexpected result item %0h", $time, got);
    end else begin
      want = expected_drive_q.pop_front();
      check_field("phase", 16'(want.phase), 16'(got.phase));
      check_field("high_side_leg", 16'(want.high_side_leg), 16'(got.high_side_leg));
      check_field("low_side_leg", 16'(want.low_side_leg), 16'(got.low_side_leg));
      check_field("comparator_channel", 16'(want.comparator_channel),
                  16'(got.comparator_channel));
      check_field("comparator_rising", 16'(want.comparator_rising),
                  16'(got.comparator_rising));
      check_field("commutated", 16'(want.commutated), 16'(got.commutated));
      check_field("start_current_conversion", 16'(want.start_current_conversion),
                  16'(got.start_current_conversion));
      check_field("commutation_total", want.commutation_total, got.commutation_total);
      check_field("revolution_ticks", 16'(want.revolution_ticks),
                  16'(got.revolution_ticks));
      check_field("revolution_done", 16'(want.revolution_done), 16'(got.revolution_done));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_result(out_item);
    if (hold_requests != holds_done) begin
      hold_left = HOLD_CYCLES;
      holds_done = hold_requests;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed;
    int k;
    idle_on = 1'b1;
    send_item(sample_item(1'b0, 8'hFF, 1'b1));
    send_item(force_item(PHASE_W'(NUM_PHASES)));
    send_item(force_item('1));
    send_item(sample_item(1'b1, 8'h00, 1'b1));
    send_item(sample_item(1'b1, 8'h55, 1'b1));
    for (k = 1; k < 6; k++)
      send_item(sample_item(~rotor_phase[0], (k == 5) ? 8'd200 : 8'(k * 17), k[0]));
    for (k = 0; k < NUM_PHASES; k++)
      send_item(force_item(PHASE_W'(k)));
    for (k = 0; k < 6; k++)
      send_item(sample_item(~rotor_phase[0], (k == 5) ? 8'd10 : 8'(k * 40), ~k[0]));
  endtask

  task automatic test_random_noise;
    repeat (150) send_item(random_item(0, 30));
  endtask

  task automatic test_commutation_runs;
    repeat (300) send_item(random_item(90, 4));
  endtask

  task automatic test_back_to_back;
    idle_on = 1'b0;
    repeat (100) send_item(random_item(80, 8));
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure;
    idle_on = 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (80) send_item(random_item(85, 5));
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_noise();
    test_commutation_runs();
    test_back_to_back();
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
